### rtl/core/avsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the audio/video sync drop decider.
package avsd_pkg;

  // Timestamp field width on the ports and the number of low bits in use.
  localparam int TS_W      = 48;
  localparam int TIME_BITS = 48;
  // Signed width of the timestamp difference.
  localparam int EARLY_W   = TIME_BITS + 1;

  localparam int LIMIT_W   = 31;
  localparam int RUN_W     = 8;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUDIO_ATTACHED  = 3'd0,
    CFG_VIDEO_TOO_LATE  = 3'd1,
    CFG_VIDEO_LATE      = 3'd2,
    CFG_AUDIO_LATE      = 3'd3,
    CFG_RUN_THRESHOLD   = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    KIND_CHECK = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_t;

  typedef struct packed {
    logic                      audio_attached;
    logic signed [LIMIT_W-1:0] video_too_late_limit;
    logic signed [LIMIT_W-1:0] video_late_limit;
    logic signed [LIMIT_W-1:0] audio_late_limit;
    logic        [RUN_W-1:0]   run_threshold;
  } cfg_t;

  typedef struct packed {
    logic            kind;
    logic [TS_W-1:0] video_timestamp;
    logic [TS_W-1:0] audio_timestamp;
  } item_t;

  typedef struct packed {
    logic             drop_video;
    logic             drop_audio;
    logic [CNT_W-1:0] video_late_events;
    logic [CNT_W-1:0] audio_late_events;
    logic [CNT_W-1:0] video_drops;
  } result_t;

endpackage

### rtl/core/avsd_in_if.sv
`timescale 1ns / 1ps
// Request channel carrying one frame check or clear request.
interface avsd_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [avsd_pkg::TS_W-1:0]   video_timestamp;
  logic [avsd_pkg::TS_W-1:0]   audio_timestamp;

  modport source (output valid, kind, video_timestamp, audio_timestamp, input ready);
  modport sink   (input valid, kind, video_timestamp, audio_timestamp, output ready);
endinterface

### rtl/core/avsd_out_if.sv
`timescale 1ns / 1ps
// Result channel carrying drop decisions and exception counters.
interface avsd_out_if;
  logic                         valid;
  logic                         ready;
  logic                         drop_video;
  logic                         drop_audio;
  logic [avsd_pkg::CNT_W-1:0]   video_late_events;
  logic [avsd_pkg::CNT_W-1:0]   audio_late_events;
  logic [avsd_pkg::CNT_W-1:0]   video_drops;

  modport source (output valid, drop_video, drop_audio, video_late_events,
                  audio_late_events, video_drops, input ready);
  modport sink   (input valid, drop_video, drop_audio, video_late_events,
                  audio_late_events, video_drops, output ready);
endinterface

### rtl/core/av_sync_drop_decider.sv
`timescale 1ns / 1ps
// Audio/video sync drop decider: top level with request and result registers.
// Path: request register, decision logic and sync state, result register.
// Throughput: one request per cycle while out_ch.ready holds; the decision logic
// and sync state resolve one per cycle between the request and result registers.
// Reset: synchronous, active low; clears the handshake state, all counters and
// runs, sets the first-frame flag and loads the default limits.
module av_sync_drop_decider (
  input  logic                            clk,
  input  logic                            rst_n,
  avsd_in_if.sink                         in_ch,
  avsd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [avsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [avsd_pkg::CFG_DAT_W-1:0]  cfg_wdata
);

  avsd_pkg::cfg_t    cfg;
  avsd_pkg::item_t   req_r;
  logic              req_valid_r;
  avsd_pkg::result_t res;
  avsd_pkg::result_t out_r;
  logic              out_valid_r;
  logic              advance;
  logic              in_take;

  avsd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Resolve the held request once the result register can take it; the
  // result register frees in the same cycle as it is read out.
  assign advance = req_valid_r && (!out_valid_r || out_ch.ready);

  // Take a new request whenever the request register empties or moves on.
  assign in_ch.ready = !req_valid_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      req_valid_r <= in_ch.valid;
    end
  end

  // Request payload: hold while stalled, load on accept.
  always_ff @(posedge clk) begin
    if (in_take) begin
      req_r.kind            <= in_ch.kind;
      req_r.video_timestamp <= in_ch.video_timestamp;
      req_r.audio_timestamp <= in_ch.audio_timestamp;
    end
  end

  avsd_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .item  (req_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Result register: drop the valid when read out and nothing follows.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.drop_video        = out_r.drop_video;
  assign out_ch.drop_audio        = out_r.drop_audio;
  assign out_ch.video_late_events = out_r.video_late_events;
  assign out_ch.audio_late_events = out_r.audio_late_events;
  assign out_ch.video_drops       = out_r.video_drops;

endmodule

### rtl/core/avsd_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file for the sync drop decider.
module avsd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [avsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [avsd_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  output avsd_pkg::cfg_t                  cfg
);

  avsd_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.audio_attached       <= 1'b0;
      cfg_r.video_too_late_limit <= -31'sd500000;
      cfg_r.video_late_limit     <= -31'sd40000;
      cfg_r.audio_late_limit     <= 31'sd40000;
      cfg_r.run_threshold        <= 8'd5;
    end else if (cfg_we) begin
      unique case (cfg_index)
        avsd_pkg::CFG_AUDIO_ATTACHED: cfg_r.audio_attached       <= cfg_wdata[0];
        avsd_pkg::CFG_VIDEO_TOO_LATE: cfg_r.video_too_late_limit <= cfg_wdata;
        avsd_pkg::CFG_VIDEO_LATE:     cfg_r.video_late_limit     <= cfg_wdata;
        avsd_pkg::CFG_AUDIO_LATE:     cfg_r.audio_late_limit     <= cfg_wdata;
        avsd_pkg::CFG_RUN_THRESHOLD:
          cfg_r.run_threshold <= cfg_wdata[avsd_pkg::RUN_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/core/avsd_core.sv
`timescale 1ns / 1ps
// Decision logic and sync state: one request is resolved per fire pulse.
module avsd_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  avsd_pkg::item_t  item,
  input  avsd_pkg::cfg_t   cfg,
  output avsd_pkg::result_t res
);

  typedef struct packed {
    logic                       hit;
    logic [avsd_pkg::RUN_W-1:0] run;
  } bump_t;

  // Advance a lateness run; a run reaching the threshold makes one event.
  function automatic bump_t bump(input logic [avsd_pkg::RUN_W-1:0] run,
                                 input logic [avsd_pkg::RUN_W-1:0] thr);
    bump_t b;
    logic [avsd_pkg::RUN_W-1:0] inc;
    inc = run + avsd_pkg::RUN_W'(1);
    if (inc >= thr) begin
      b.hit = 1'b1;
      b.run = '0;
    end else begin
      b.hit = 1'b0;
      b.run = inc;
    end
    return b;
  endfunction

  logic                        first_frame_r,  first_frame_nxt;
  logic                        dropped_last_r, dropped_last_nxt;
  logic [avsd_pkg::RUN_W-1:0]  vrun_r, vrun_nxt;
  logic [avsd_pkg::RUN_W-1:0]  arun_r, arun_nxt;
  logic [avsd_pkg::CNT_W-1:0]  vcnt_r, vcnt_nxt;
  logic [avsd_pkg::CNT_W-1:0]  acnt_r, acnt_nxt;
  logic [avsd_pkg::CNT_W-1:0]  dcnt_r, dcnt_nxt;
  logic                        dv, da;

  logic [avsd_pkg::TIME_BITS-1:0]      vts, ats;
  logic signed [avsd_pkg::EARLY_W-1:0] early;
  logic signed [avsd_pkg::EARLY_W-1:0] too_late_lim, late_lim, alate_lim;
  bump_t                               vb, ab;

  assign vts   = item.video_timestamp[avsd_pkg::TIME_BITS-1:0];
  assign ats   = item.audio_timestamp[avsd_pkg::TIME_BITS-1:0];
  assign early = $signed({1'b0, vts}) - $signed({1'b0, ats});

  assign too_late_lim = {{(avsd_pkg::EARLY_W-avsd_pkg::LIMIT_W)
                          {cfg.video_too_late_limit[avsd_pkg::LIMIT_W-1]}},
                         cfg.video_too_late_limit};
  assign late_lim     = {{(avsd_pkg::EARLY_W-avsd_pkg::LIMIT_W)
                          {cfg.video_late_limit[avsd_pkg::LIMIT_W-1]}},
                         cfg.video_late_limit};
  assign alate_lim    = {{(avsd_pkg::EARLY_W-avsd_pkg::LIMIT_W)
                          {cfg.audio_late_limit[avsd_pkg::LIMIT_W-1]}},
                         cfg.audio_late_limit};

  assign vb = bump(vrun_r, cfg.run_threshold);
  assign ab = bump(arun_r, cfg.run_threshold);

  always_comb begin
    first_frame_nxt  = first_frame_r;
    dropped_last_nxt = dropped_last_r;
    vrun_nxt         = vrun_r;
    arun_nxt         = arun_r;
    vcnt_nxt         = vcnt_r;
    acnt_nxt         = acnt_r;
    dcnt_nxt         = dcnt_r;
    dv               = 1'b0;
    da               = 1'b0;
    if (item.kind == avsd_pkg::KIND_CLEAR) begin
      vcnt_nxt = '0;
      acnt_nxt = '0;
      dcnt_nxt = '0;
      vrun_nxt = '0;
      arun_nxt = '0;
    end else if (first_frame_r) begin
      first_frame_nxt  = 1'b0;
      dropped_last_nxt = 1'b0;
    end else if (!cfg.audio_attached) begin
      // no audio clock: leave everything as it is
    end else if (ats == '0) begin
      dropped_last_nxt = 1'b0;
    end else begin
      if (early < too_late_lim) begin
        vrun_nxt = vb.run;
        vcnt_nxt = vcnt_r + avsd_pkg::CNT_W'(vb.hit);
      end else if (early < late_lim && !dropped_last_r) begin
        dv       = 1'b1;
        dcnt_nxt = dcnt_r + avsd_pkg::CNT_W'(1);
      end else if (early > alate_lim) begin
        da       = 1'b1;
        arun_nxt = ab.run;
        acnt_nxt = acnt_r + avsd_pkg::CNT_W'(ab.hit);
      end else begin
        vrun_nxt = '0;
        arun_nxt = '0;
      end
      dropped_last_nxt = dv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_frame_r  <= 1'b1;
      dropped_last_r <= 1'b0;
      vrun_r         <= '0;
      arun_r         <= '0;
      vcnt_r         <= '0;
      acnt_r         <= '0;
      dcnt_r         <= '0;
    end else if (fire) begin
      first_frame_r  <= first_frame_nxt;
      dropped_last_r <= dropped_last_nxt;
      vrun_r         <= vrun_nxt;
      arun_r         <= arun_nxt;
      vcnt_r         <= vcnt_nxt;
      acnt_r         <= acnt_nxt;
      dcnt_r         <= dcnt_nxt;
    end
  end

  assign res.drop_video        = dv;
  assign res.drop_audio        = da;
  assign res.video_late_events = vcnt_nxt;
  assign res.audio_late_events = acnt_nxt;
  assign res.video_drops       = dcnt_nxt;

endmodule
